@@ rtl/qpsc_pkg.sv @@
package qpsc_pkg;

	// item operation codes
	localparam logic OPER_EDGE = 1'b0;
	localparam logic OPER_TICK = 1'b1;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_SPEED_SCALE    = 3'd0,
		CFG_SMOOTH_ALPHA   = 3'd1,
		CFG_GAIN_P         = 3'd2,
		CFG_GAIN_I         = 3'd3,
		CFG_GAIN_D         = 3'd4,
		CFG_PERIOD_SECONDS = 3'd5,
		CFG_PERIOD_INVERSE = 3'd6,
		CFG_INTEGRAL_LIMIT = 3'd7
	} cfg_idx_t;

	// datapath widths
	localparam int OPND_W = 33;
	localparam int PROD_W = 2 * OPND_W;
	localparam int ACC_W  = PROD_W + 1;

	// fixed-point constants
	localparam logic signed [ACC_W-1:0] S32_MAX    = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] S32_MIN    = -ACC_W'(64'sd2147483648);
	localparam logic signed [ACC_W-1:0] FULL_SCALE = ACC_W'(64'sd6553600);
	localparam logic signed [ACC_W-1:0] RND16_BIAS = ACC_W'(64'sd32768);
	localparam logic signed [ACC_W-1:0] RND24_BIAS = ACC_W'(64'sd8388608);
	// ceil(2^30 / 100), exact for dividends below 2^23
	localparam logic [23:0] RECIP_100 = 24'd10737419;
	localparam int ALPHA_ONE = 65536;

	// microcode fields
	typedef enum logic [4:0] {
		OP_ZERO, OP_DELTA, OP_SCALE, OP_ALPHA, OP_ALPHA_C, OP_FILT, OP_TARGET,
		OP_ONE, OP_MONE, OP_ERR, OP_GAIN_P, OP_GAIN_I, OP_GAIN_D, OP_PSEC,
		OP_PINV, OP_INTEG, OP_LASTERR, OP_TMP, OP_P, OP_I, OP_D, OP_CTL,
		OP_SIGN, OP_PWMTOP, OP_RECIP
	} opnd_t;

	typedef enum logic {
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_TMP, DST_FILT, DST_ERR, DST_P, DST_INTEG, DST_I, DST_D,
		DST_LASTERR, DST_CTL
	} dest_t;

	typedef enum logic [2:0] {
		POST_PASS, POST_RND16, POST_RND24, POST_FLR16, POST_FLR30,
		POST_CLAMP_LIM, POST_CLAMP_FULL
	} post_t;

	typedef enum logic {
		JMP_NONE,
		JMP_CTL_ZERO
	} jmp_t;

	localparam int NUM_STEPS = 22;
	localparam int STEP_W = $clog2(NUM_STEPS);
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_FINISH = STEP_W'(NUM_STEPS - 1);

	typedef struct packed {
		opnd_t   a;
		opnd_t   b;
		acc_op_t acc;
		dest_t   dest;
		post_t   post;
		jmp_t    jmp;
		step_t   target;
		logic    last;
	} uword_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MUL,
		SEQ_ACC,
		SEQ_WB
	} seq_state_t;

	typedef struct packed {
		uword_t word;
		logic   mul_en;
		logic   acc_en;
		logic   wb_en;
		logic   done;
		logic   busy;
	} seq_ctrl_t;

	// control program for one tick
	function automatic uword_t ucode_rom(step_t step);
		uword_t w;
		w = '{OP_ZERO, OP_ZERO, ACC_LOAD, DST_NONE, POST_PASS, JMP_NONE, '0, 1'b1};
		case (step)
			// raw speed
			5'd0:  w = '{OP_DELTA, OP_SCALE, ACC_LOAD, DST_TMP, POST_PASS, JMP_NONE, '0, 1'b0};
			// exponential average
			5'd1:  w = '{OP_ALPHA, OP_TMP, ACC_LOAD, DST_NONE, POST_PASS, JMP_NONE, '0, 1'b0};
			5'd2:  w = '{OP_ALPHA_C, OP_FILT, ACC_ADD, DST_FILT, POST_RND16, JMP_NONE, '0, 1'b0};
			// error
			5'd3:  w = '{OP_TARGET, OP_ONE, ACC_LOAD, DST_NONE, POST_PASS, JMP_NONE, '0, 1'b0};
			5'd4:  w = '{OP_FILT, OP_MONE, ACC_ADD, DST_ERR, POST_PASS, JMP_NONE, '0, 1'b0};
			// proportional term
			5'd5:  w = '{OP_ERR, OP_GAIN_P, ACC_LOAD, DST_P, POST_RND16, JMP_NONE, '0, 1'b0};
			// integral accumulation and clamp
			5'd6:  w = '{OP_ERR, OP_PSEC, ACC_LOAD, DST_TMP, POST_RND24, JMP_NONE, '0, 1'b0};
			5'd7:  w = '{OP_INTEG, OP_ONE, ACC_LOAD, DST_NONE, POST_PASS, JMP_NONE, '0, 1'b0};
			5'd8:  w = '{OP_TMP, OP_ONE, ACC_ADD, DST_INTEG, POST_CLAMP_LIM, JMP_NONE, '0, 1'b0};
			5'd9:  w = '{OP_INTEG, OP_GAIN_I, ACC_LOAD, DST_I, POST_RND16, JMP_NONE, '0, 1'b0};
			// derivative term
			5'd10: w = '{OP_ERR, OP_ONE, ACC_LOAD, DST_NONE, POST_PASS, JMP_NONE, '0, 1'b0};
			5'd11: w = '{OP_LASTERR, OP_MONE, ACC_ADD, DST_TMP, POST_PASS, JMP_NONE, '0, 1'b0};
			5'd12: w = '{OP_TMP, OP_PINV, ACC_LOAD, DST_TMP, POST_RND16, JMP_NONE, '0, 1'b0};
			5'd13: w = '{OP_TMP, OP_GAIN_D, ACC_LOAD, DST_D, POST_RND16, JMP_NONE, '0, 1'b0};
			5'd14: w = '{OP_ERR, OP_ONE, ACC_LOAD, DST_LASTERR, POST_PASS, JMP_NONE, '0, 1'b0};
			// control sum and limit
			5'd15: w = '{OP_P, OP_ONE, ACC_LOAD, DST_NONE, POST_PASS, JMP_NONE, '0, 1'b0};
			5'd16: w = '{OP_I, OP_ONE, ACC_ADD, DST_NONE, POST_PASS, JMP_NONE, '0, 1'b0};
			5'd17: w = '{OP_D, OP_ONE, ACC_ADD, DST_CTL, POST_CLAMP_FULL, JMP_NONE, '0, 1'b0};
			// magnitude, skip duty when control is zero
			5'd18: w = '{OP_CTL, OP_SIGN, ACC_LOAD, DST_TMP, POST_PASS, JMP_CTL_ZERO,
					STEP_FINISH, 1'b0};
			// duty = floor(floor(mag * top / 2^16) / 100)
			5'd19: w = '{OP_TMP, OP_PWMTOP, ACC_LOAD, DST_TMP, POST_FLR16, JMP_NONE, '0, 1'b0};
			5'd20: w = '{OP_TMP, OP_RECIP, ACC_LOAD, DST_TMP, POST_FLR30, JMP_NONE, '0, 1'b0};
			default: w = '{OP_ZERO, OP_ZERO, ACC_LOAD, DST_NONE, POST_PASS, JMP_NONE, '0, 1'b1};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/qpsc_if.sv @@
// input item channel
interface qpsc_item_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic               edge_on_b;
	logic               level_a;
	logic               level_b;
	logic               setpoint_valid;
	logic signed [31:0] setpoint;

	modport source (
		output valid, operation, edge_on_b, level_a, level_b, setpoint_valid, setpoint,
		input  ready
	);
	modport sink (
		input  valid, operation, edge_on_b, level_a, level_b, setpoint_valid, setpoint,
		output ready
	);
endinterface

// result item channel
interface qpsc_result_if;
	logic               valid;
	logic               ready;
	logic        [12:0] forward_level;
	logic        [12:0] reverse_level;
	logic signed [31:0] speed_estimate;

	modport source (
		output valid, forward_level, reverse_level, speed_estimate,
		input  ready
	);
	modport sink (
		input  valid, forward_level, reverse_level, speed_estimate,
		output ready
	);
endinterface

@@ rtl/quadrature_pid_speed_controller.sv @@
// Speed controller for one motor: encoder edge transactions update a x4 quadrature
// count and give no result. A control tick transaction starts a 22-step
// microprogram on one shared 33x33 signed multiplier with an accumulator; each
// step runs through the multiply, accumulate and round/saturate/write back states,
// and the duty steps are skipped when the limited control signal is zero; the
// sequencer returns to idle before the next item is taken. Items are taken
// whenever the microprogram is idle, also while an earlier result still waits in
// the output register; a finishing tick holds in its last step until that register
// is free. Configuration writes take effect at once and are meant to happen between
// ticks.
module quadrature_pid_speed_controller #(
	parameter int PWM_TOP = 5000
) (
	input  logic                 clk,
	input  logic                 arst_n,
	qpsc_item_if.sink            items,
	qpsc_result_if.source        results,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int W = qpsc_pkg::OPND_W;

	// configuration registers
	logic [23:0] speed_scale_q;
	logic [16:0] smoothing_alpha_q;
	logic [23:0] gain_p_q;
	logic [23:0] gain_i_q;
	logic [23:0] gain_d_q;
	logic [23:0] period_seconds_q;
	logic [31:0] period_inverse_q;
	logic [30:0] integral_limit_q;

	// architectural state
	logic        [31:0] tick_count_q;
	logic        [31:0] last_tick_count_q;
	logic signed [31:0] target_speed_q;
	logic signed [31:0] filtered_speed_q;
	logic signed [31:0] error_integral_q;
	logic signed [31:0] last_error_q;

	// scratch registers
	logic signed [31:0] delta_q;
	logic signed [31:0] tmp_q;
	logic signed [31:0] err_q;
	logic signed [31:0] p_q;
	logic signed [31:0] i_q;
	logic signed [31:0] d_q;
	logic signed [31:0] ctl_q;

	// datapath
	logic signed [qpsc_pkg::PROD_W-1:0] prod_q;
	logic signed [qpsc_pkg::ACC_W-1:0]  acc_q;
	logic signed [W-1:0]                opnd_a;
	logic signed [W-1:0]                opnd_b;
	logic signed [qpsc_pkg::ACC_W-1:0]  rnd_sum;
	logic signed [qpsc_pkg::ACC_W-1:0]  shifted;
	logic signed [qpsc_pkg::ACC_W-1:0]  lim_ext;
	logic signed [31:0]                 wb_val;
	logic        [16:0]                 alpha_eff;
	logic        [16:0]                 alpha_c;

	// handshake and sequencing
	qpsc_pkg::seq_ctrl_t ctrl;
	logic                in_fire;
	logic                tick_start;
	logic                out_valid_q;
	logic                out_stall;
	logic                up;
	logic        [12:0]  fwd_q;
	logic        [12:0]  rev_q;
	logic signed [31:0]  meas_q;

	assign items.ready = !ctrl.busy;
	assign in_fire     = items.valid && items.ready;
	assign tick_start  = in_fire && (items.operation == qpsc_pkg::OPER_TICK);
	assign out_stall   = out_valid_q && !results.ready;

	qpsc_ucode_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (tick_start),
		.ctl_zero  (ctl_q == 32'sd0),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	// smoothing weight, values above one act as one
	always_comb begin
		if (smoothing_alpha_q > 17'(qpsc_pkg::ALPHA_ONE))
			alpha_eff = 17'(qpsc_pkg::ALPHA_ONE);
		else
			alpha_eff = smoothing_alpha_q;
		alpha_c = 17'(qpsc_pkg::ALPHA_ONE) - alpha_eff;
	end

	function automatic logic signed [W-1:0] sx32(logic signed [31:0] v);
		return {v[31], v};
	endfunction

	// operand select
	function automatic logic signed [W-1:0] opnd_sel(qpsc_pkg::opnd_t s);
		logic signed [W-1:0] v;
		case (s)
			qpsc_pkg::OP_DELTA:   v = sx32(delta_q);
			qpsc_pkg::OP_SCALE:   v = $signed(W'(speed_scale_q));
			qpsc_pkg::OP_ALPHA:   v = $signed(W'(alpha_eff));
			qpsc_pkg::OP_ALPHA_C: v = $signed(W'(alpha_c));
			qpsc_pkg::OP_FILT:    v = sx32(filtered_speed_q);
			qpsc_pkg::OP_TARGET:  v = sx32(target_speed_q);
			qpsc_pkg::OP_ONE:     v = W'(1);
			qpsc_pkg::OP_MONE:    v = '1;
			qpsc_pkg::OP_ERR:     v = sx32(err_q);
			qpsc_pkg::OP_GAIN_P:  v = $signed(W'(gain_p_q));
			qpsc_pkg::OP_GAIN_I:  v = $signed(W'(gain_i_q));
			qpsc_pkg::OP_GAIN_D:  v = $signed(W'(gain_d_q));
			qpsc_pkg::OP_PSEC:    v = $signed(W'(period_seconds_q));
			qpsc_pkg::OP_PINV:    v = $signed(W'(period_inverse_q));
			qpsc_pkg::OP_INTEG:   v = sx32(error_integral_q);
			qpsc_pkg::OP_LASTERR: v = sx32(last_error_q);
			qpsc_pkg::OP_TMP:     v = sx32(tmp_q);
			qpsc_pkg::OP_P:       v = sx32(p_q);
			qpsc_pkg::OP_I:       v = sx32(i_q);
			qpsc_pkg::OP_D:       v = sx32(d_q);
			qpsc_pkg::OP_CTL:     v = sx32(ctl_q);
			qpsc_pkg::OP_SIGN:    v = ctl_q[31] ? '1 : W'(1);
			qpsc_pkg::OP_PWMTOP:  v = W'(PWM_TOP);
			qpsc_pkg::OP_RECIP:   v = $signed(W'(qpsc_pkg::RECIP_100));
			default:              v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opnd_a = opnd_sel(ctrl.word.a);
		opnd_b = opnd_sel(ctrl.word.b);
	end

	// round, shift and saturate the accumulator
	always_comb begin
		lim_ext = $signed(qpsc_pkg::ACC_W'(integral_limit_q));
		case (ctrl.word.post)
			qpsc_pkg::POST_RND16: rnd_sum = acc_q + qpsc_pkg::RND16_BIAS;
			qpsc_pkg::POST_RND24: rnd_sum = acc_q + qpsc_pkg::RND24_BIAS;
			default:              rnd_sum = acc_q;
		endcase
		case (ctrl.word.post)
			qpsc_pkg::POST_RND16, qpsc_pkg::POST_FLR16: shifted = rnd_sum >>> 16;
			qpsc_pkg::POST_RND24:                       shifted = rnd_sum >>> 24;
			qpsc_pkg::POST_FLR30:                       shifted = rnd_sum >>> 30;
			default:                                    shifted = rnd_sum;
		endcase
		case (ctrl.word.post)
			qpsc_pkg::POST_CLAMP_LIM: begin
				if (shifted > lim_ext)
					wb_val = lim_ext[31:0];
				else if (shifted < -lim_ext)
					wb_val = -lim_ext[31:0];
				else
					wb_val = shifted[31:0];
			end
			qpsc_pkg::POST_CLAMP_FULL: begin
				if (shifted > qpsc_pkg::FULL_SCALE)
					wb_val = qpsc_pkg::FULL_SCALE[31:0];
				else if (shifted < -qpsc_pkg::FULL_SCALE)
					wb_val = -qpsc_pkg::FULL_SCALE[31:0];
				else
					wb_val = shifted[31:0];
			end
			default: begin
				if (shifted > qpsc_pkg::S32_MAX)
					wb_val = qpsc_pkg::S32_MAX[31:0];
				else if (shifted < qpsc_pkg::S32_MIN)
					wb_val = qpsc_pkg::S32_MIN[31:0];
				else
					wb_val = shifted[31:0];
			end
		endcase
	end

	// multiplier and accumulator
	always_ff @(posedge clk) begin
		if (ctrl.mul_en)
			prod_q <= opnd_a * opnd_b;
		if (ctrl.acc_en) begin
			if (ctrl.word.acc == qpsc_pkg::ACC_LOAD)
				acc_q <= qpsc_pkg::ACC_W'(prod_q);
			else
				acc_q <= acc_q + qpsc_pkg::ACC_W'(prod_q);
		end
	end

	// scratch write back
	always_ff @(posedge clk) begin
		if (tick_start)
			delta_q <= tick_count_q - last_tick_count_q;
		if (ctrl.wb_en) begin
			case (ctrl.word.dest)
				qpsc_pkg::DST_TMP: tmp_q <= wb_val;
				qpsc_pkg::DST_ERR: err_q <= wb_val;
				qpsc_pkg::DST_P:   p_q   <= wb_val;
				qpsc_pkg::DST_I:   i_q   <= wb_val;
				qpsc_pkg::DST_D:   d_q   <= wb_val;
				default:           tmp_q <= tmp_q;
			endcase
		end
	end

	// quadrature count direction
	assign up = items.edge_on_b ? (items.level_a != items.level_b)
	                            : (items.level_a == items.level_b);

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q      <= '0;
			last_tick_count_q <= '0;
			target_speed_q    <= '0;
			filtered_speed_q  <= '0;
			error_integral_q  <= '0;
			last_error_q      <= '0;
			ctl_q             <= '0;
		end else begin
			if (in_fire && items.operation == qpsc_pkg::OPER_EDGE)
				tick_count_q <= up ? tick_count_q + 32'd1 : tick_count_q - 32'd1;
			if (tick_start) begin
				last_tick_count_q <= tick_count_q;
				if (items.setpoint_valid)
					target_speed_q <= items.setpoint;
			end
			if (ctrl.wb_en) begin
				case (ctrl.word.dest)
					qpsc_pkg::DST_FILT:    filtered_speed_q <= wb_val;
					qpsc_pkg::DST_INTEG:   error_integral_q <= wb_val;
					qpsc_pkg::DST_LASTERR: last_error_q     <= wb_val;
					qpsc_pkg::DST_CTL:     ctl_q            <= wb_val;
					default:               ctl_q            <= ctl_q;
				endcase
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q     <= 24'd114382;
			smoothing_alpha_q <= 17'd16384;
			gain_p_q          <= 24'd327680;
			gain_i_q          <= 24'd262144;
			gain_d_q          <= 24'd0;
			period_seconds_q  <= 24'd167772;
			period_inverse_q  <= 32'd6553600;
			integral_limit_q  <= 31'd3276800;
		end else if (cfg_we) begin
			case (qpsc_pkg::cfg_idx_t'(cfg_index))
				qpsc_pkg::CFG_SPEED_SCALE:    speed_scale_q     <= cfg_data[23:0];
				qpsc_pkg::CFG_SMOOTH_ALPHA:   smoothing_alpha_q <= cfg_data[16:0];
				qpsc_pkg::CFG_GAIN_P:         gain_p_q          <= cfg_data[23:0];
				qpsc_pkg::CFG_GAIN_I:         gain_i_q          <= cfg_data[23:0];
				qpsc_pkg::CFG_GAIN_D:         gain_d_q          <= cfg_data[23:0];
				qpsc_pkg::CFG_PERIOD_SECONDS: period_seconds_q  <= cfg_data[23:0];
				qpsc_pkg::CFG_PERIOD_INVERSE: period_inverse_q  <= cfg_data;
				qpsc_pkg::CFG_INTEGRAL_LIMIT: integral_limit_q  <= cfg_data[30:0];
				default:                      speed_scale_q     <= speed_scale_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.done) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.done) begin
			fwd_q  <= (ctl_q > 32'sd0) ? tmp_q[12:0] : 13'd0;
			rev_q  <= (ctl_q < 32'sd0) ? tmp_q[12:0] : 13'd0;
			meas_q <= filtered_speed_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.forward_level  = fwd_q;
	assign results.reverse_level  = rev_q;
	assign results.speed_estimate = meas_q;

`ifndef ASSERT_OFF
	// a result appears only when the microprogram finishes
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.done))
		else $error("result without finished microprogram");

	// an accepted tick starts the sequencer
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		tick_start |=> ctrl.busy)
		else $error("tick accepted but sequencer idle");

	// limited control stays within full scale
	a_ctl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q <= 32'sd6553600) && (ctl_q >= -32'sd6553600))
		else $error("control signal beyond full scale");

	// only one drive pin active
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (fwd_q == 13'd0 || rev_q == 13'd0))
		else $error("both drive levels nonzero");
`endif

endmodule

@@ rtl/qpsc_ucode_seq.sv @@
module qpsc_ucode_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 ctl_zero,
	input  logic                 out_stall,
	output qpsc_pkg::seq_ctrl_t  ctrl
);

	qpsc_pkg::seq_state_t state_q;
	qpsc_pkg::seq_state_t state_nxt;
	qpsc_pkg::step_t      step_q;
	qpsc_pkg::uword_t     word;

	// control store read
	assign word = qpsc_pkg::ucode_rom(step_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			qpsc_pkg::SEQ_IDLE: begin
				if (start)
					state_nxt = qpsc_pkg::SEQ_MUL;
			end
			qpsc_pkg::SEQ_MUL: state_nxt = qpsc_pkg::SEQ_ACC;
			qpsc_pkg::SEQ_ACC: state_nxt = qpsc_pkg::SEQ_WB;
			qpsc_pkg::SEQ_WB: begin
				if (!word.last)
					state_nxt = qpsc_pkg::SEQ_MUL;
				else if (!out_stall)
					state_nxt = qpsc_pkg::SEQ_IDLE;
			end
			default: state_nxt = qpsc_pkg::SEQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl        = '0;
		ctrl.word   = word;
		ctrl.busy   = (state_q != qpsc_pkg::SEQ_IDLE);
		case (state_q)
			qpsc_pkg::SEQ_MUL: ctrl.mul_en = 1'b1;
			qpsc_pkg::SEQ_ACC: ctrl.acc_en = 1'b1;
			qpsc_pkg::SEQ_WB: begin
				ctrl.wb_en = 1'b1;
				ctrl.done  = word.last && !out_stall;
			end
			default: ctrl.mul_en = 1'b0;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qpsc_pkg::SEQ_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == qpsc_pkg::SEQ_IDLE) begin
				step_q <= '0;
			end else if (state_q == qpsc_pkg::SEQ_WB && !word.last) begin
				if (word.jmp == qpsc_pkg::JMP_CTL_ZERO && ctl_zero)
					step_q <= word.target;
				else
					step_q <= step_q + qpsc_pkg::STEP_W'(1);
			end
		end
	end

endmodule

@@ bench/quadrature_pid_speed_controller_tb.sv @@
`timescale 1ns / 1ps

module quadrature_pid_speed_controller_tb;
	import qpsc_pkg::*;

	localparam int     PWM_SPAN   = 5000;
	localparam longint FULL_DRIVE = 64'sd6553600;
	localparam longint SAT_HI     = 64'sd2147483647;
	localparam longint SAT_LO     = -64'sd2147483648;
	localparam int     SETTLE_CYC = 80;
	localparam int     SEG_ITEMS  = 80;

	typedef struct {
		logic               operation;
		logic               edge_on_b;
		logic               level_a;
		logic               level_b;
		logic               setpoint_valid;
		logic signed [31:0] setpoint;
	} item_t;

	typedef struct {
		logic        [12:0] forward_level;
		logic        [12:0] reverse_level;
		logic signed [31:0] speed_estimate;
	} drive_t;

	typedef enum {SET_ZERO, SET_TOP, SET_RANDOM} setting_t;

	// speed loop predictor plus queue of drive levels still owed by the block
	class drive_scoreboard;
		int unsigned speed_scale, smooth_alpha, gain_p, gain_i, gain_d;
		int unsigned period_s, period_inv, int_limit;
		logic        [31:0] tick_count, last_tick;
		logic signed [31:0] target, filtered, integral, last_err;
		drive_t             drive_due[$];
		int                 mismatches;

		function new();
			speed_scale  = 114382;
			smooth_alpha = 16384;
			gain_p       = 327680;
			gain_i       = 262144;
			gain_d       = 0;
			period_s     = 167772;
			period_inv   = 6553600;
			int_limit    = 3276800;
			tick_count   = '0;
			last_tick    = '0;
			target       = '0;
			filtered     = '0;
			integral     = '0;
			last_err     = '0;
			mismatches   = 0;
		endfunction

		function longint clip32(longint x);
			if (x > SAT_HI) return SAT_HI;
			if (x < SAT_LO) return SAT_LO;
			return x;
		endfunction

		// add half an lsb, then floor shift
		function longint rnd_shift(longint x, int s);
			return (x + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [31:0] v);
			case (idx)
				CFG_SPEED_SCALE:    speed_scale  = v & 32'h00FF_FFFF;
				CFG_SMOOTH_ALPHA:   smooth_alpha = v & 32'h0001_FFFF;
				CFG_GAIN_P:         gain_p       = v & 32'h00FF_FFFF;
				CFG_GAIN_I:         gain_i       = v & 32'h00FF_FFFF;
				CFG_GAIN_D:         gain_d       = v & 32'h00FF_FFFF;
				CFG_PERIOD_SECONDS: period_s     = v & 32'h00FF_FFFF;
				CFG_PERIOD_INVERSE: period_inv   = v;
				CFG_INTEGRAL_LIMIT: int_limit    = v & 32'h7FFF_FFFF;
				default: ;
			endcase
		endfunction

		function void note_item(item_t it);
			longint delta, raw, wt, filt, err, p_term, integ, lim, i_term;
			longint diff, rate, d_term, ctl, mag, duty;
			logic   same, up;
			drive_t due;
			// encoder edge: x4 count only
			if (it.operation == OPER_EDGE) begin
				same = (it.level_a == it.level_b);
				up = it.edge_on_b ? !same : same;
				tick_count = up ? tick_count + 32'd1 : tick_count - 32'd1;
				return;
			end
			if (it.setpoint_valid)
				target = it.setpoint;
			// raw speed from wrapped tick delta
			delta = longint'($signed(tick_count - last_tick));
			last_tick = tick_count;
			raw = clip32(delta * longint'(speed_scale));
			// exponential average, weight capped at one
			wt = (smooth_alpha > 65536) ? 64'sd65536 : longint'(smooth_alpha);
			filt = clip32(rnd_shift(wt * raw + (64'sd65536 - wt) * longint'(filtered), 16));
			filtered = 32'(filt);
			err = clip32(longint'(target) - filt);
			p_term = clip32(rnd_shift(longint'(gain_p) * err, 16));
			// clamped integral
			lim = longint'(int_limit);
			integ = longint'(integral) + clip32(rnd_shift(err * longint'(period_s), 24));
			if (integ > lim) integ = lim;
			if (integ < -lim) integ = -lim;
			integral = 32'(integ);
			i_term = clip32(rnd_shift(longint'(gain_i) * integ, 16));
			// derivative
			diff = clip32(err - longint'(last_err));
			rate = clip32(rnd_shift(diff * longint'(period_inv), 16));
			d_term = clip32(rnd_shift(longint'(gain_d) * rate, 16));
			last_err = 32'(err);
			// limit and split into forward / reverse levels
			ctl = p_term + i_term + d_term;
			if (ctl > FULL_DRIVE) ctl = FULL_DRIVE;
			if (ctl < -FULL_DRIVE) ctl = -FULL_DRIVE;
			mag = (ctl < 0) ? -ctl : ctl;
			duty = mag * PWM_SPAN / FULL_DRIVE;
			due.forward_level  = (ctl > 0) ? 13'(duty) : 13'd0;
			due.reverse_level  = (ctl < 0) ? 13'(duty) : 13'd0;
			due.speed_estimate = filtered;
			drive_due.push_back(due);
		endfunction

		function void check_drive(drive_t got);
			drive_t due;
			if (drive_due.size() == 0) begin
				mismatches++;
				$display("%0t: expected no drive transaction, actual fwd %0d rev %0d speed %0d",
					$time, got.forward_level, got.reverse_level, got.speed_estimate);
				return;
			end
			due = drive_due.pop_front();
			if (got.forward_level !== due.forward_level
					|| got.reverse_level !== due.reverse_level
					|| got.speed_estimate !== due.speed_estimate) begin
				mismatches++;
				$display("%0t: drive mismatch expected fwd %0d rev %0d speed %0d",
					$time, due.forward_level, due.reverse_level, due.speed_estimate);
				$display("%0t:                actual fwd %0d rev %0d speed %0d",
					$time, got.forward_level, got.reverse_level, got.speed_estimate);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	cfg_idx_t    cfg_index;
	logic [31:0] cfg_data;
	int          send_idle_pct;
	int          recv_stall_pct;

	drive_scoreboard board;

	qpsc_item_if   item_ch();
	qpsc_result_if drive_ch();

	quadrature_pid_speed_controller #(
		.PWM_TOP(PWM_SPAN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_ch),
		.results(drive_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic item_t make_item(logic op, logic on_b, logic a, logic b, logic sv,
			logic signed [31:0] sp);
		item_t it;
		it.operation      = op;
		it.edge_on_b      = on_b;
		it.level_a        = a;
		it.level_b        = b;
		it.setpoint_valid = sv;
		it.setpoint       = sp;
		return it;
	endfunction

	// target speeds: mostly moderate, some extremes and full range
	function automatic logic signed [31:0] pick_setpoint();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $urandom;
			default: return 32'($urandom_range(0, 1 << 24)) - 32'sd8388608;
		endcase
	endfunction

	// edge with levels chosen to count in the given direction
	function automatic item_t edge_item(logic up);
		logic on_b, a;
		on_b = 1'($urandom);
		a = 1'($urandom);
		return make_item(OPER_EDGE, on_b, a, (up ^ on_b) ? a : !a, 1'($urandom), $urandom);
	endfunction

	function automatic item_t tick_item();
		return make_item(OPER_TICK, 1'($urandom), 1'($urandom), 1'($urandom),
			$urandom_range(0, 9) < 4, pick_setpoint());
	endfunction

	function automatic item_t any_item();
		return make_item(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
			1'($urandom), $urandom);
	endfunction

	function automatic logic [31:0] reg_value(cfg_idx_t r, setting_t mode);
		logic [31:0] top, typical;
		case (r)
			CFG_SMOOTH_ALPHA:   begin top = 32'h0001_FFFF; typical = 65536;   end
			CFG_SPEED_SCALE:    begin top = 32'h00FF_FFFF; typical = 500000;  end
			CFG_PERIOD_SECONDS: begin top = 32'h00FF_FFFF; typical = 1 << 22; end
			CFG_PERIOD_INVERSE: begin top = 32'hFFFF_FFFF; typical = 1 << 24; end
			CFG_INTEGRAL_LIMIT: begin top = 32'h7FFF_FFFF; typical = 1 << 24; end
			default:            begin top = 32'h00FF_FFFF; typical = 1 << 20; end
		endcase
		if (mode == SET_ZERO) return '0;
		if (mode == SET_TOP) return top;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return top;
			2: return $urandom & top;
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	task automatic send_item(item_t it);
		// random sender gaps
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			item_ch.valid = 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		item_ch.valid          = 1'b1;
		item_ch.operation      = it.operation;
		item_ch.edge_on_b      = it.edge_on_b;
		item_ch.level_a        = it.level_a;
		item_ch.level_b        = it.level_b;
		item_ch.setpoint_valid = it.setpoint_valid;
		item_ch.setpoint       = it.setpoint;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		board.note_item(it);
	endtask

	// wait until every owed result is in and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (board.drive_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic load_settings(setting_t mode);
		logic [31:0] v;
		for (int r = 0; r < 8; r++) begin
			v = reg_value(cfg_idx_t'(r), mode);
			@(negedge clk);
			cfg_we    = 1'b1;
			cfg_index = cfg_idx_t'(r);
			cfg_data  = v;
			@(posedge clk);
			board.set_reg(cfg_idx_t'(r), v);
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// mostly steady rotation bursts closed by a tick, some noise
	task automatic run_traffic(int budget);
		int   sent, len, pick;
		logic up;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 99) < 85) begin
				up = 1'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 40) len = $urandom_range(0, 3);
				else if (pick < 96) len = $urandom_range(4, 16);
				else len = $urandom_range(128, 160);
				repeat (len) begin
					send_item(edge_item(up));
					sent++;
				end
				send_item(tick_item());
				sent++;
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_item(any_item());
					sent++;
				end
			end
		end
	endtask

	// result side: random stalls at the falling edge
	initial begin
		drive_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			drive_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result side: check each accepted transaction
	initial begin
		drive_t got;
		forever begin
			@(posedge clk);
			if (drive_ch.valid && drive_ch.ready) begin
				got.forward_level  = drive_ch.forward_level;
				got.reverse_level  = drive_ch.reverse_level;
				got.speed_estimate = drive_ch.speed_estimate;
				board.check_drive(got);
			end
		end
	end

	// main sequence
	initial begin
		board = new();
		send_idle_pct          = 0;
		recv_stall_pct         = 0;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_SPEED_SCALE;
		cfg_data               = '0;
		item_ch.valid          = 1'b0;
		item_ch.operation      = OPER_EDGE;
		item_ch.edge_on_b      = 1'b0;
		item_ch.level_a        = 1'b0;
		item_ch.level_b        = 1'b0;
		item_ch.setpoint_valid = 1'b0;
		item_ch.setpoint       = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: zero control, every edge kind, ignored fields, extreme targets
		send_item(make_item(OPER_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0));
		for (int k = 0; k < 8; k++)
			send_item(make_item(OPER_EDGE, k[2], k[1], k[0], 1'b0, 32'sd0));
		repeat (4) send_item(make_item(OPER_EDGE, 1'b0, 1'b1, 1'b1, 1'b0, 32'sd0));
		send_item(make_item(OPER_TICK, 1'b1, 1'b1, 1'b0, 1'b1, 32'sh7FFF_FFFF));
		send_item(make_item(OPER_EDGE, 1'b1, 1'b0, 1'b1, 1'b1, 32'sh8000_0000));
		send_item(make_item(OPER_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 32'sh8000_0000));
		send_item(make_item(OPER_TICK, 1'b0, 1'b1, 1'b1, 1'b1, 32'sh8000_0000));
		send_item(make_item(OPER_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 32'sd0));
		repeat (3) send_item(make_item(OPER_EDGE, 1'b1, 1'b1, 1'b1, 1'b0, 32'sd0));
		send_item(make_item(OPER_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 32'sd65536));

		// random segments: settings change, idling pattern every two segments
		for (int seg = 0; seg < 8; seg++) begin
			if (seg > 0) begin
				settle();
				load_settings(seg == 1 ? SET_TOP : (seg == 2 ? SET_ZERO : SET_RANDOM));
			end
			case (seg / 2)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			run_traffic(SEG_ITEMS);
		end
		settle();

		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
